>>> rtl/core/fnvp_pkg.sv
package fnvp_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam bit SLOTS_POW2  = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

    // remainder pass: one byte of (hash >> 1) per cycle, top byte first
    localparam int MOD_W      = SLOT_W + 8;
    localparam int MOD_CHUNKS = 8;
    localparam int CHUNK_W    = $clog2(MOD_CHUNKS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] FNV_BASIS      = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]  FNV_MULT_LOW   = 9'h1B3;
    localparam int          FNV_MULT_SHIFT = 40;

    localparam logic [7:0] MARK_EMPTY = 8'hFF;
    localparam logic [7:0] FP_SUBST   = 8'hFE;
    localparam int         FP_SHIFT   = 57;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic ST_INSERTED = 1'b0;
    localparam logic ST_FULL     = 1'b1;

    typedef enum logic {
        K_CLEAR,
        K_INSERT
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] hash;
        logic [31:0] key_ref;
        logic [63:0] entry_value;
    } t_cmd;

endpackage

>>> rtl/core/fnvp_queue.sv
module fnvp_queue import fnvp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_buf[r_rd];

    assign n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/fnvp_front.sv
module fnvp_front import fnvp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,
    input  logic         i_s_tlast,
    input  logic         i_s_tuser,
    input  logic         i_q_full,
    output logic         o_q_push,
    output t_cmd         o_q_cmd
);

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] m;
        m = h ^ {56'd0, b};
        return (m << FNV_MULT_SHIFT) + (m * {55'd0, FNV_MULT_LOW});
    endfunction

    logic [63:0] r_hash;
    logic [63:0] n_hash;
    logic        accept;
    logic        key_done;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && !i_q_full;
    assign n_hash     = fnv_step(r_hash, i_s_tdata[7:0]);
    assign key_done   = (i_s_tuser == OP_CLEAR) || i_s_tlast;
    assign o_q_push   = accept && key_done;

    assign o_q_cmd.kind        = (i_s_tuser == OP_BYTE) ? K_INSERT : K_CLEAR;
    assign o_q_cmd.hash        = n_hash;
    assign o_q_cmd.key_ref     = i_s_tdata[39:8];
    assign o_q_cmd.entry_value = i_s_tdata[103:40];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else if (accept) begin
            r_hash <= key_done ? FNV_BASIS : n_hash;
        end
    end

endmodule

>>> rtl/core/fnvp_back.sv
module fnvp_back import fnvp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tuser
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_PROBE
    } t_state;

    function automatic logic [7:0] fingerprint(input logic [63:0] h);
        logic [7:0] f;
        f = {1'b1, h[FP_SHIFT +: 7]};
        return (f == MARK_EMPTY) ? FP_SUBST : f;
    endfunction

    function automatic logic [SLOT_W-1:0] mod_step(input logic [SLOT_W-1:0] rem,
                                                   input logic [7:0] c);
        logic [MOD_W-1:0] t;
        logic [MOD_W-1:0] d;
        t = {rem, c};
        for (int k = 7; k >= 0; k--) begin
            d = MOD_W'(TABLE_SLOTS) << k;
            if (t >= d) begin
                t = t - d;
            end
        end
        return t[SLOT_W-1:0];
    endfunction

    t_state               r_state;
    logic [TABLE_SLOTS-1:0] r_used;
    logic [CNT_W-1:0]     r_count;
    logic [SLOT_W-1:0]    r_idx;
    logic [63:0]          r_q;
    logic [CHUNK_W-1:0]   r_chunk;
    logic [7:0]           r_fp;
    logic [31:0]          r_key;
    logic [63:0]          r_val;

    logic                 r_out_valid;
    logic                 r_out_status;
    logic [3:0]           r_out_slot;
    logic [7:0]           r_out_fp;
    logic [4:0]           r_out_count;

    logic [7:0]           r_mark_mem [TABLE_SLOTS];
    logic [31:0]          r_key_mem  [TABLE_SLOTS];
    logic [63:0]          r_val_mem  [TABLE_SLOTS];

    logic                 out_free;
    logic                 is_full;
    logic                 slot_free;
    logic                 store;
    logic                 emit;
    logic [SLOT_W-1:0]    n_idx;
    logic [SLOT_W-1:0]    n_rem;
    logic [CNT_W-1:0]     n_count;
    logic [SLOT_W+3:0]    slot_ext;
    logic [CNT_W+4:0]     count_ext;

    assign out_free  = !r_out_valid || i_m_tready;
    assign is_full   = (r_count == CNT_W'(TABLE_SLOTS));
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid &&
                       !((i_q_cmd.kind == K_INSERT) && is_full && !out_free);
    assign slot_free = !r_used[r_idx];
    assign store     = (r_state == S_PROBE) && slot_free && out_free;
    assign emit      = (o_q_pop && (i_q_cmd.kind == K_INSERT) && is_full) || store;
    assign n_idx     = (r_idx == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : r_idx + 1'b1;
    assign n_rem     = mod_step(r_idx, r_q[63:56]);
    assign n_count   = r_count + 1'b1;
    assign slot_ext  = {4'd0, r_idx};
    assign count_ext = {5'd0, n_count};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {7'd0, r_out_count, r_out_fp, r_out_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_cmd.kind == K_CLEAR) begin
                            r_used  <= '0;
                            r_count <= '0;
                        end else if (is_full) begin
                            r_used       <= '0;
                            r_count      <= '0;
                            r_out_status <= ST_FULL;
                            r_out_slot   <= '0;
                            r_out_fp     <= '0;
                            r_out_count  <= '0;
                        end else begin
                            r_fp    <= fingerprint(i_q_cmd.hash);
                            r_key   <= i_q_cmd.key_ref;
                            r_val   <= i_q_cmd.entry_value;
                            r_q     <= {1'b0, i_q_cmd.hash[63:1]};
                            r_chunk <= '0;
                            if (SLOTS_POW2) begin
                                r_idx   <= i_q_cmd.hash[SLOT_W:1];
                                r_state <= S_PROBE;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_MOD;
                            end
                        end
                    end
                end
                S_MOD: begin
                    r_idx   <= n_rem;
                    r_q     <= r_q << 8;
                    r_chunk <= r_chunk + 1'b1;
                    if (r_chunk == CHUNK_W'(MOD_CHUNKS - 1)) begin
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (slot_free) begin
                        if (out_free) begin
                            r_used[r_idx] <= 1'b1;
                            r_count       <= n_count;
                            r_out_status  <= ST_INSERTED;
                            r_out_slot    <= slot_ext[3:0];
                            r_out_fp      <= r_fp;
                            r_out_count   <= count_ext[4:0];
                            r_state       <= S_IDLE;
                        end
                    end else begin
                        r_idx <= n_idx;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mark_mem[r_idx] <= r_fp;
            r_key_mem[r_idx]  <= r_key;
            r_val_mem[r_idx]  <= r_val;
        end
    end

endmodule

>>> rtl/core/fnv_hashed_probe_table_insert.sv
// Channel  Dir  tdata (low bit up)                        tlast     tuser
// s_axis   in   key_byte[7:0] key_ref[39:8] value[103:40]  key_end   opcode
// m_axis   out  slot[3:0] fingerprint[11:4] count[16:12]   -         status
//
// Key bytes without end are taken one per cycle unless the queue is full.
// A key's last byte is queued, then dequeued and probed slot by slot
// (1 to TABLE_SLOTS examined), after a start-index remainder pass when
// TABLE_SLOTS is not a power of two; a full table answers on dequeue.
// Reset clears the occupancy bits directly; no sweep.
// A two-entry command queue sits between hashing and probing; the input
// stalls only when it is full, probing stalls only on an untaken result.
module fnv_hashed_probe_table_insert import fnvp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,  // key_byte, key_ref, entry_value
    input  logic         i_s_tlast,  // key_end
    input  logic         i_s_tuser,  // opcode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [23:0]  o_m_tdata,  // slot, fingerprint, entry_count, zero pad
    output logic         o_m_tuser   // status
);

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd q_in;
    t_cmd q_out;

    fnvp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in)
    );

    fnvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    fnvp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> rtl/core/fnvp_checker.sv
module fnvp_checker import fnvp_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [23:0]  o_m_tdata,
    input logic         o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat dropped or changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat right after reset");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_FULL) |-> (o_m_tdata == 24'd0))
        else $error("full status with non-zero fields");

    a_fp_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_INSERTED) |->
            o_m_tdata[11] && (o_m_tdata[11:4] != MARK_EMPTY) && (o_m_tdata[23:17] == 7'd0))
        else $error("bad fingerprint on insert");

endmodule

bind fnv_hashed_probe_table_insert fnvp_checker u_fnvp_checker (.*);

>>> tb/tb_fnv_hashed_probe_table_insert.sv
module tb_fnv_hashed_probe_table_insert;
    import fnvp_pkg::*;

    localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01B3;
    localparam int          STALL_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 300;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        fp;
        logic [CNT_W-1:0]  count;
    } t_placement;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;   // key_byte, key_ref, entry_value
    logic         s_tlast = 1'b0; // key_end
    logic         s_tuser = 1'b0; // opcode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;        // slot, fingerprint, entry_count, zero pad
    logic         m_tuser;        // status

    // predictor state
    logic [63:0] hash_acc;
    logic [7:0]  slot_mark [TABLE_SLOTS];
    int unsigned n_occupied;

    t_placement placement_q[$];
    int n_err = 0;
    int n_beats = 0;
    int n_results = 0;
    int n_full = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    fnv_hashed_probe_table_insert u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic void wipe_table();
        foreach (slot_mark[i]) slot_mark[i] = MARK_EMPTY;
        n_occupied = 0;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // returns 1 when the beat produces a placement result
    function automatic bit fold_and_place(input logic op, input logic [7:0] kb,
                                          input logic kend, output t_placement res);
        logic [63:0] h;
        logic [7:0]  fp;
        int          start;
        int          idx;
        res = '0;
        if (op == OP_CLEAR) begin
            wipe_table();
            hash_acc = FNV_BASIS;
            return 1'b0;
        end
        h = (hash_acc ^ {56'b0, kb}) * FNV_PRIME;
        if (!kend) begin
            hash_acc = h;
            return 1'b0;
        end
        hash_acc = FNV_BASIS;
        fp = {1'b1, h[63:57]};
        if (fp == MARK_EMPTY) fp = FP_SUBST;
        start = int'((h >> 1) % 64'(TABLE_SLOTS));
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            idx = (start + k) % TABLE_SLOTS;
            if (slot_mark[idx] == MARK_EMPTY) begin
                slot_mark[idx] = fp;
                n_occupied++;
                res.status = ST_INSERTED;
                res.slot   = idx[SLOT_W-1:0];
                res.fp     = fp;
                res.count  = n_occupied[CNT_W-1:0];
                return 1'b1;
            end
        end
        wipe_table();
        res.status = ST_FULL;
        return 1'b1;
    endfunction

    task automatic send_beat(input logic op, input logic [7:0] kb, input logic kend,
                             input logic [31:0] kref, input logic [63:0] kval);
        t_placement res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= kend;
        s_tdata  <= {kval, kref, kb};
        do @(posedge clk); while (!s_tready);
        n_beats++;
        if (fold_and_place(op, kb, kend, res)) placement_q = {placement_q, res};
    endtask

    task automatic send_clear();
        send_beat(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)), $urandom,
                  rand64());
    endtask

    task automatic send_key(input int len);
        for (int i = 0; i < len; i++)
            send_beat(OP_BYTE, 8'($urandom_range(255)), i == len - 1, $urandom, rand64());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (placement_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_edge_keys();
        send_beat(OP_CLEAR, 8'hFF, 1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(OP_BYTE, 8'h00, 1'b1, 32'h0, 64'h0);
        send_beat(OP_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_clear_mid_key();
        send_beat(OP_BYTE, 8'h5A, 1'b0, $urandom, rand64());
        send_beat(OP_CLEAR, 8'h00, 1'b0, 32'h0, 64'h0);
        send_beat(OP_BYTE, 8'hA5, 1'b0, $urandom, rand64());
        send_beat(OP_BYTE, 8'h3C, 1'b1, $urandom, rand64());
        wait_drained();
    endtask

    // two-byte key whose hash top bits are all ones, so the fingerprint is substituted
    task automatic test_fp_substitute();
        logic [63:0] h1;
        logic [63:0] h2;
        logic [7:0]  b0;
        logic [7:0]  b1;
        bit          found;
        found = 1'b0;
        for (int a = 0; a < 256 && !found; a++) begin
            h1 = (FNV_BASIS ^ 64'(a)) * FNV_PRIME;
            for (int b = 0; b < 256 && !found; b++) begin
                h2 = (h1 ^ 64'(b)) * FNV_PRIME;
                if (h2[63:57] == 7'h7F) begin
                    b0 = 8'(a);
                    b1 = 8'(b);
                    found = 1'b1;
                end
            end
        end
        if (found) begin
            send_beat(OP_BYTE, b0, 1'b0, $urandom, rand64());
            send_beat(OP_BYTE, b1, 1'b1, $urandom, rand64());
            wait_drained();
        end
    endtask

    task automatic test_fill_to_full();
        send_clear();
        for (int i = 0; i <= TABLE_SLOTS; i++)
            send_beat(OP_BYTE, 8'(i * 37 + 11), 1'b1, $urandom, rand64());
        wait_drained();
    endtask

    task automatic test_output_stall();
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_beat(OP_BYTE, 8'($urandom_range(255)), 1'b1, $urandom, rand64());
        wait_drained();
    endtask

    task automatic test_random_keys(input int n_target);
        int stop_at;
        int r;
        stop_at = n_beats + n_target;
        while (n_beats < stop_at) begin
            r = $urandom_range(99);
            if (r < 1) begin
                send_clear();
            end else if (r < 3) begin
                // abandoned key
                for (int i = $urandom_range(3, 1); i > 0; i--)
                    send_beat(OP_BYTE, 8'($urandom_range(255)), 1'b0, $urandom, rand64());
                send_clear();
            end else if (r < 10) begin
                send_key($urandom_range(16, 5));
            end else begin
                send_key($urandom_range(3, 1));
            end
        end
        wait_drained();
    endtask

    always @(posedge clk) begin : rx_side
        t_placement want;
        if (rst_n && m_tready && m_tvalid) begin
            if (placement_q.size() == 0) begin
                $error("unexpected result beat: status %0b tdata %h", m_tuser, m_tdata);
                n_err++;
            end else begin
                want = placement_q.pop_front();
                n_results++;
                if (want.status == ST_FULL) n_full++;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    n_err++;
                end
                if (m_tdata[SLOT_W-1:0] !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_tdata[SLOT_W-1:0]);
                    n_err++;
                end
                if (m_tdata[SLOT_W+7:SLOT_W] !== want.fp) begin
                    $error("fingerprint: expected %h, got %h", want.fp,
                           m_tdata[SLOT_W+7:SLOT_W]);
                    n_err++;
                end
                if (m_tdata[SLOT_W+8+CNT_W-1:SLOT_W+8] !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count,
                           m_tdata[SLOT_W+8+CNT_W-1:SLOT_W+8]);
                    n_err++;
                end
            end
        end
        if (hold_left == 0 && hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tready && m_tvalid)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        wipe_table();
        hash_acc = FNV_BASIS;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 32;
        snk_idle_pct = 54;
        test_edge_keys();
        test_clear_mid_key();
        test_fp_substitute();
        test_fill_to_full();
        test_random_keys(380);

        src_idle_pct = 54;
        snk_idle_pct = 32;
        test_random_keys(380);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_output_stall();
        test_random_keys(380);

        repeat (40) @(posedge clk);
        $display("%0d beats sent, %0d results checked, %0d of them table-full",
                 n_beats, n_results, n_full);
        $display("edge keys, clears, fingerprint substitution, %0d-cycle output hold",
                 HOLD_CYCLES);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
